/* hw/rtl/pyramid_shape_function_eval_defines.svh */
// Assertion macros shared by the pyramid shape function block.
`ifndef PYRAMID_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define PYRAMID_SHAPE_FUNCTION_EVAL_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pse: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pse: next-cycle check failed");

`endif

/* hw/rtl/pse_pkg.sv */
// Shared constants, types and the saturation function of the pyramid shape block.
`default_nettype none
package pse_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int QUOT_BITS     = 40;
  localparam int MAG_W         = 72;
  localparam int RES_W         = 18;
  localparam int IN_W          = 48;
  localparam int OUT_W         = 80;

  localparam logic [2:0] NODE_APEX = 3'd4;

  // Bit k is set when corner k has a negative x or y sign.
  localparam logic [3:0] CORNER_SX_NEG = 4'b1100;
  localparam logic [3:0] CORNER_SY_NEG = 4'b0110;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(131071);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(131072);
  localparam logic [RES_W-1:0] RES_MAX = 18'h1FFFF;
  localparam logic [RES_W-1:0] RES_MIN = 18'h20000;

  typedef struct packed {
    logic [RES_W-1:0] v;
    logic             sat;
  } sat_t;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic [RES_W-1:0] dx;
    logic [RES_W-1:0] dy;
    logic [RES_W-1:0] dz;
    logic             sat;
  } node_res_t;

  function automatic sat_t sat18(input logic neg, input logic [MAG_W-1:0] mag);
    sat_t r;
    r.sat = 1'b0;
    if (!neg) begin
      r.v = mag[RES_W-1:0];
      if (mag > POS_LIM) begin
        r.v   = RES_MAX;
        r.sat = 1'b1;
      end
    end else begin
      r.v = RES_W'(0) - mag[RES_W-1:0];
      if (mag > NEG_LIM) begin
        r.v   = RES_MIN;
        r.sat = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/pse_div.sv */
// Pipelined restoring divider with round-half-up and clamp, one quotient bit per stage.
`default_nettype none
module pse_div #(
  parameter int NW = 47,
  parameter int DW = 34,
  parameter int QB = 40
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QB:0]   quot
);

  logic [DW-1:0] rem_r   [0:QB];
  logic [QB-1:0] low_r   [0:QB];
  logic [DW-1:0] den_r   [0:QB];
  logic          clamp_r [0:QB];
  logic [NW-1:0] hi;
  logic [DW:0]   twice;
  logic          up;

  assign hi = num >> QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= hi[DW-1:0];
      low_r[0]   <= num[QB-1:0];
      den_r[0]   <= den;
      clamp_r[0] <= hi >= NW'(den);
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DW:0] cand;
    logic        ge;
    assign cand = {rem_r[i-1], low_r[i-1][QB-1]};
    assign ge   = cand >= {1'b0, den_r[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]   <= ge ? DW'(cand - {1'b0, den_r[i-1]}) : cand[DW-1:0];
        low_r[i]   <= {low_r[i-1][QB-2:0], ge};
        den_r[i]   <= den_r[i-1];
        clamp_r[i] <= clamp_r[i-1];
      end
    end
  end

  assign twice = {rem_r[QB], 1'b0};
  assign up    = twice >= {1'b0, den_r[QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= clamp_r[QB] ? ((QB+1)'(1) << QB) : ({1'b0, low_r[QB]} + (QB+1)'(up));
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pyramid_shape_function_eval.sv */
// Top level: shape values and gradients of a linear five-node pyramid element.
//
//  channel  dir  payload
//  s_*      in   beat = one (x, y, z) triple
//  m_*      out  beat = one node result, five per triple, tlast on the apex
//
// Input beats pass stages 0 to 3, the 40-step divider pipeline, stage E1 and the
// output stage. Each triple occupies the output channel for five beats; a new
// triple is taken only when the output stage is empty or its apex beat is taken.
// Reset is synchronous and clears all valid bits and the node counter.
// Every stage advances together; a stall on m_tready freezes the whole pipeline.
`default_nettype none
`include "pyramid_shape_function_eval_defines.svh"
module pyramid_shape_function_eval #(
  parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
  input  wire logic [pse_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // node_index [2:0], shape_value [20:3], deriv_x [38:21], deriv_y [56:39],
  // deriv_z [74:57], zero [79:75]
  output logic [pse_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast,
  // saturated [0]
  output logic                           m_tuser
);

  localparam int F    = FRAC_BITS;
  localparam int DMW  = ((F > 15) ? F : 15) + 2;
  localparam int DSW  = DMW + 1;
  localparam int DW   = 2 * DMW;
  localparam int NW   = ((2 * DMW + F - 1) > 46) ? (2 * DMW + F - 1) : 46;
  localparam int QB   = pse_pkg::QUOT_BITS;
  localparam int PW   = 2 * DSW;
  localparam int RW   = QB + 2;
  localparam int TW   = ((PW > RW) ? PW : RW) + 2;
  localparam int DLAT = QB + 2;
  localparam int NDIV = 7;

  localparam int DV_RAT = 0;
  localparam int DV_NXP = 1;
  localparam int DV_NXM = 2;
  localparam int DV_NYP = 3;
  localparam int DV_NYM = 4;
  localparam int DV_NZP = 5;
  localparam int DV_NZM = 6;

  localparam logic signed [DSW-1:0] ONE_D = DSW'(64'd1 << F);
  localparam logic [DMW-1:0]        ONE_M = DMW'(64'd1 << F);
  localparam logic [TW:0]           HALF  = (TW+1)'(1) << (F + 1);

  typedef struct packed {
    logic signed [15:0]   z;
    logic [3:0][PW-1:0]   prod;
    logic [NDIV-1:0]      neg;
  } side_t;

  logic en;
  logic take;

  // Stage 0
  logic               v0;
  logic signed [15:0] x0, y0, z0;
  // Stage 1
  logic               v1;
  logic signed [15:0] x1, y1, z1;
  logic signed [DSW-1:0] d1, fpx1, fmx1, fpy1, fmy1;
  logic signed [31:0] xy1;
  logic [DMW-1:0]        dsh_mag_c, dde_mag_c;
  logic signed [DSW-1:0] dde_c;
  // Stage 2
  logic               v2;
  logic signed [15:0] z2;
  logic signed [31:0] xy2;
  logic signed [47:0] xyz2;
  logic [DMW-1:0]     dsh_mag2, dde_mag2;
  logic               dneg2;
  logic [DW-1:0]      dsq2;
  logic signed [DSW:0] nyp2, nym2, nxp2, nxm2;
  logic signed [PW-1:0] prod2 [4];
  // Stage 3
  logic               v3;
  side_t              side3;
  logic [NW-1:0]      dnum3 [NDIV];
  logic [DW-1:0]      dden3 [NDIV];
  // Divider outputs and side line
  logic [QB:0]        dq [NDIV];
  side_t              side_dly [0:DLAT-1];
  logic [DLAT-1:0]    vdly;
  // Stage E1
  logic               ve1;
  logic signed [15:0] ze1;
  logic signed [TW-1:0] te1 [4];
  pse_pkg::sat_t      dxe1 [4], dye1 [4], dze1 [4];
  // Output stage
  logic               ve2;
  logic [2:0]         cnt;
  pse_pkg::node_res_t res2 [5];
  pse_pkg::node_res_t sel;

  assign take     = ve2 && m_tready && (cnt == pse_pkg::NODE_APEX);
  assign en       = !ve2 || take;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vdly <= '0;
      ve1 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      vdly <= {vdly[DLAT-2:0], v3};
      ve1 <= vdly[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= s_tdata[15:0];
      y0 <= s_tdata[31:16];
      z0 <= s_tdata[47:32];

      x1   <= x0;
      y1   <= y0;
      z1   <= z0;
      d1   <= ONE_D - DSW'(z0);
      xy1  <= x0 * y0;
      fpx1 <= ONE_D + DSW'(x0);
      fmx1 <= ONE_D - DSW'(x0);
      fpy1 <= ONE_D + DSW'(y0);
      fmy1 <= ONE_D - DSW'(y0);
    end
  end

  always_comb begin
    logic               dz;
    logic signed [DSW-1:0] dde;
    logic [DMW-1:0]     dmag;
    dz   = (d1 == '0);
    dde  = dz ? DSW'(1) : d1;
    dmag = d1[DSW-1] ? DMW'(-d1) : DMW'(d1);
    dsh_mag_c = dz ? ONE_M : dmag;
    dde_mag_c = dz ? DMW'(1) : dmag;
    dde_c     = dde;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2       <= z1;
      xy2      <= xy1;
      xyz2     <= xy1 * z1;
      dsh_mag2 <= dsh_mag_c;
      dde_mag2 <= dde_mag_c;
      dneg2    <= d1[DSW-1];
      dsq2     <= dde_mag_c * dde_mag_c;
      nyp2     <= (DSW+1)'(dde_c) + (DSW+1)'(y1);
      nym2     <= (DSW+1)'(dde_c) - (DSW+1)'(y1);
      nxp2     <= (DSW+1)'(dde_c) + (DSW+1)'(x1);
      nxm2     <= (DSW+1)'(dde_c) - (DSW+1)'(x1);
      prod2[0] <= fpx1 * fpy1;
      prod2[1] <= fpx1 * fmy1;
      prod2[2] <= fmx1 * fmy1;
      prod2[3] <= fmx1 * fpy1;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [DW+1:0] nzp, nzm;
    logic [47:0]          xyz_m;
    logic [DSW:0]         m_nyp, m_nym, m_nxp, m_nxm;
    logic [DW+1:0]        m_nzp, m_nzm;
    nzp   = (DW+2)'(xy2) - $signed({2'b00, dsq2});
    nzm   = -(DW+2)'(xy2) - $signed({2'b00, dsq2});
    xyz_m = xyz2[47] ? 48'(-xyz2) : 48'(xyz2);
    m_nyp = nyp2[DSW] ? (DSW+1)'(-nyp2) : (DSW+1)'(nyp2);
    m_nym = nym2[DSW] ? (DSW+1)'(-nym2) : (DSW+1)'(nym2);
    m_nxp = nxp2[DSW] ? (DSW+1)'(-nxp2) : (DSW+1)'(nxp2);
    m_nxm = nxm2[DSW] ? (DSW+1)'(-nxm2) : (DSW+1)'(nxm2);
    m_nzp = nzp[DW+1] ? (DW+2)'(-nzp) : (DW+2)'(nzp);
    m_nzm = nzm[DW+1] ? (DW+2)'(-nzm) : (DW+2)'(nzm);
    if (en) begin
      dnum3[DV_RAT] <= NW'(xyz_m);
      dden3[DV_RAT] <= DW'(dsh_mag2);
      dnum3[DV_NXP] <= NW'(m_nyp) << (F - 2);
      dden3[DV_NXP] <= DW'(dde_mag2);
      dnum3[DV_NXM] <= NW'(m_nym) << (F - 2);
      dden3[DV_NXM] <= DW'(dde_mag2);
      dnum3[DV_NYP] <= NW'(m_nxp) << (F - 2);
      dden3[DV_NYP] <= DW'(dde_mag2);
      dnum3[DV_NYM] <= NW'(m_nxm) << (F - 2);
      dden3[DV_NYM] <= DW'(dde_mag2);
      dnum3[DV_NZP] <= NW'(m_nzp) << (F - 2);
      dden3[DV_NZP] <= dsq2;
      dnum3[DV_NZM] <= NW'(m_nzm) << (F - 2);
      dden3[DV_NZM] <= dsq2;
      side3.z <= z2;
      for (int k = 0; k < 4; k++) begin
        side3.prod[k] <= prod2[k];
      end
      side3.neg[DV_RAT] <= xyz2[47] ^ dneg2;
      side3.neg[DV_NXP] <= nyp2[DSW] ^ dneg2;
      side3.neg[DV_NXM] <= nym2[DSW] ^ dneg2;
      side3.neg[DV_NYP] <= nxp2[DSW] ^ dneg2;
      side3.neg[DV_NYM] <= nxm2[DSW] ^ dneg2;
      side3.neg[DV_NZP] <= nzp[DW+1];
      side3.neg[DV_NZM] <= nzm[DW+1];
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    pse_div #(
      .NW(NW),
      .DW(DW),
      .QB(QB)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (dnum3[j]),
      .den (dden3[j]),
      .quot(dq[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= side3;
      for (int i = 1; i < DLAT; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_t                sd;
    logic signed [RW-1:0] rat_s;
    logic signed [TW-1:0] zf;
    logic                 sxn, syn, same;
    int                   ix, iy, iz;
    sd    = side_dly[DLAT-1];
    rat_s = sd.neg[DV_RAT] ? -$signed({1'b0, dq[DV_RAT]}) : $signed({1'b0, dq[DV_RAT]});
    zf    = TW'(sd.z) <<< F;
    if (en) begin
      ze1 <= sd.z;
      for (int k = 0; k < 4; k++) begin
        sxn  = pse_pkg::CORNER_SX_NEG[k];
        syn  = pse_pkg::CORNER_SY_NEG[k];
        same = (sxn == syn);
        ix   = syn ? DV_NXM : DV_NXP;
        iy   = sxn ? DV_NYM : DV_NYP;
        iz   = same ? DV_NZP : DV_NZM;
        te1[k] <= TW'($signed(sd.prod[k])) - zf + (same ? TW'(rat_s) : -TW'(rat_s));
        dxe1[k] <= pse_pkg::sat18((sd.neg[ix] ^ sxn) && (dq[ix] != '0),
                                  pse_pkg::MAG_W'(dq[ix]));
        dye1[k] <= pse_pkg::sat18((sd.neg[iy] ^ syn) && (dq[iy] != '0),
                                  pse_pkg::MAG_W'(dq[iy]));
        dze1[k] <= pse_pkg::sat18(sd.neg[iz] && (dq[iz] != '0),
                                  pse_pkg::MAG_W'(dq[iz]));
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [TW-1:0]  tm;
    logic [TW:0]    q;
    pse_pkg::sat_t  sv, av, ad;
    logic [15:0]    zm;
    if (rst) begin
      ve2 <= 1'b0;
      cnt <= '0;
    end else if (en) begin
      ve2 <= ve1;
      cnt <= '0;
    end else if (m_tready) begin
      cnt <= cnt + 3'd1;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        tm = te1[k][TW-1] ? TW'(-te1[k]) : TW'(te1[k]);
        q  = ({1'b0, tm} + HALF) >> (F + 2);
        sv = pse_pkg::sat18(te1[k][TW-1] && (q != '0), pse_pkg::MAG_W'(q));
        res2[k].value <= sv.v;
        res2[k].dx    <= dxe1[k].v;
        res2[k].dy    <= dye1[k].v;
        res2[k].dz    <= dze1[k].v;
        res2[k].sat   <= sv.sat | dxe1[k].sat | dye1[k].sat | dze1[k].sat;
      end
      zm = ze1[15] ? 16'(-ze1) : 16'(ze1);
      av = pse_pkg::sat18(ze1[15], pse_pkg::MAG_W'(zm));
      ad = pse_pkg::sat18(1'b0, pse_pkg::MAG_W'(ONE_M));
      res2[4].value <= av.v;
      res2[4].dx    <= '0;
      res2[4].dy    <= '0;
      res2[4].dz    <= ad.v;
      res2[4].sat   <= av.sat | ad.sat;
    end
  end

  always_comb begin
    unique case (cnt)
      3'd0:    sel = res2[0];
      3'd1:    sel = res2[1];
      3'd2:    sel = res2[2];
      3'd3:    sel = res2[3];
      default: sel = res2[4];
    endcase
  end

  assign m_tvalid = ve2;
  assign m_tlast  = (cnt == pse_pkg::NODE_APEX);
  assign m_tuser  = sel.sat;
  assign m_tdata  = {5'b00000, sel.dz, sel.dy, sel.dx, sel.value, cnt};

  `PSE_ASSERT_NEXT(a_node_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
  `PSE_ASSERT_IMPL(a_apex_flat, m_tvalid && m_tlast, m_tdata[56:21] == '0)
  `PSE_ASSERT_IMPL(a_take_at_end, s_tvalid && s_tready, !m_tvalid || (m_tready && m_tlast))

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the pyramid shape function block: random and corner coordinates against a predictor.
`default_nettype none
module tb_top;

  localparam int FB = pse_pkg::FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint QCAP_V = 64'sd1 << pse_pkg::QUOT_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [pse_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [pse_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  typedef struct {
    logic [2:0] node;
    logic [pse_pkg::RES_W-1:0] value;
    logic [pse_pkg::RES_W-1:0] dx;
    logic [pse_pkg::RES_W-1:0] dy;
    logic [pse_pkg::RES_W-1:0] dz;
    logic last;
    logic sat;
  } node_beat_t;

  node_beat_t expected_nodes[$];
  int errors = 0;
  int sink_gap = 0;
  bit sink_idle_ok = 1'b1;
  bit src_idle_ok = 1'b1;
  bit hold_sink = 1'b0;

  pyramid_shape_function_eval dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Rounded n * 2^sh / d on magnitudes, ties away from zero, capped.
  function automatic longint round_div(longint n, longint d, int sh);
    longint q, r;
    q = n / d;
    r = n % d;
    if (q >= QCAP_V) return QCAP_V;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 1;
      end else begin
        r = r + r;
      end
      if (q >= QCAP_V) return QCAP_V;
    end
    if (r >= d - r) q++;
    return q;
  endfunction

  function automatic logic [pse_pkg::RES_W-1:0] clip18(bit neg, longint mag, inout logic sat);
    if (!neg) begin
      if (mag > 131071) begin
        sat = 1'b1;
        return pse_pkg::RES_MAX;
      end
      return pse_pkg::RES_W'(mag);
    end
    if (mag > 131072) begin
      sat = 1'b1;
      return pse_pkg::RES_MIN;
    end
    return pse_pkg::RES_W'(-mag);
  endfunction

  function automatic logic [pse_pkg::RES_W-1:0] fixed_quot(longint num, longint den, int sh,
                                                          inout logic sat);
    bit neg;
    longint q;
    neg = (num < 0) != (den < 0);
    q = round_div(abs64(num), abs64(den), sh);
    return clip18(neg && q != 0, q, sat);
  endfunction

  task automatic predict_nodes(logic signed [15:0] cx, logic signed [15:0] cy,
                               logic signed [15:0] cz);
    longint x, y, z, d, dsh, dder, xy, rat, dsq, sx, sy, t, q;
    node_beat_t b;
    x = cx;
    y = cy;
    z = cz;
    d = ONE - z;
    dsh = (d == 0) ? ONE : d;
    dder = (d == 0) ? 1 : d;
    xy = x * y;
    q = round_div(abs64(xy * z), abs64(dsh), 0);
    rat = (((xy * z) < 0) != (dsh < 0)) ? -q : q;
    dsq = dder * dder;
    for (int k = 0; k < 4; k++) begin
      sx = pse_pkg::CORNER_SX_NEG[k] ? -1 : 1;
      sy = pse_pkg::CORNER_SY_NEG[k] ? -1 : 1;
      b.sat = 1'b0;
      b.node = 3'(k);
      t = (ONE + sx * x) * (ONE + sy * y) - z * ONE + sx * sy * rat;
      b.value = fixed_quot(t, ONE * 4, 0, b.sat);
      b.dx = fixed_quot(sx * (dder + sy * y), 4 * dder, FB, b.sat);
      b.dy = fixed_quot(sy * (dder + sx * x), 4 * dder, FB, b.sat);
      b.dz = fixed_quot(sx * sy * xy - dsq, 4 * dsq, FB, b.sat);
      b.last = 1'b0;
      expected_nodes.push_back(b);
    end
    b.sat = 1'b0;
    b.node = pse_pkg::NODE_APEX;
    b.value = clip18(z < 0, abs64(z), b.sat);
    b.dx = '0;
    b.dy = '0;
    b.dz = clip18(1'b0, ONE, b.sat);
    b.last = 1'b1;
    expected_nodes.push_back(b);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic send_coord(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    int gap;
    if (src_idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cz, cy, cx};
    predict_nodes(cx, cy, cz);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || hold_sink) begin
      m_tready <= 1'b0;
    end else if (sink_idle_ok && sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (sink_idle_ok && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    node_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_nodes.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[2:0], 0);
      end else begin
        e = expected_nodes.pop_front();
        if (m_tdata[2:0] != e.node) report_mismatch("node_index", m_tdata[2:0], e.node);
        if (m_tdata[20:3] != e.value) report_mismatch("shape_value", m_tdata[20:3], e.value);
        if (m_tdata[38:21] != e.dx) report_mismatch("deriv_x", m_tdata[38:21], e.dx);
        if (m_tdata[56:39] != e.dy) report_mismatch("deriv_y", m_tdata[56:39], e.dy);
        if (m_tdata[74:57] != e.dz) report_mismatch("deriv_z", m_tdata[74:57], e.dz);
        if (m_tdata[79:75] != 5'd0) report_mismatch("pad", m_tdata[79:75], 0);
        if (m_tlast != e.last) report_mismatch("last_node", m_tlast, e.last);
        if (m_tuser != e.sat) report_mismatch("saturated", m_tuser, e.sat);
      end
    end
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'(-$urandom_range(0, 16384));
      3: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_corners();
    logic [15:0] vals[8] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                             16'h3FFF, 16'h4001, 16'hFFFF};
    foreach (vals[i]) send_coord(vals[i], vals[(i + 3) % 8], vals[i]);
    send_coord(16'h2000, 16'hE000, 16'h4000);
    send_coord(16'h7FFF, 16'h7FFF, 16'h4000);
    send_coord(16'h8000, 16'h7FFF, 16'h4000);
    send_coord(16'h7FFF, 16'h8000, 16'h4001);
    send_coord(16'h8000, 16'h8000, 16'h3FFF);
    send_coord(16'h8000, 16'h8000, 16'h8000);
    send_coord(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_coord(16'h1234, 16'hABCD, 16'h4002);
    send_coord(16'h0000, 16'h0000, 16'h4000);
  endtask

  task automatic test_random();
    for (int i = 0; i < 300; i++) send_coord(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_coord(16'($urandom), 16'($urandom), pick_coord());
    join
  endtask

  task automatic test_full_rate();
    src_idle_ok = 1'b0;
    sink_idle_ok = 1'b0;
    for (int i = 0; i < 80; i++) send_coord(pick_coord(), pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corners();
    test_random();
    test_backpressure();
    test_full_rate();
    s_tvalid <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_div.sv
hw/rtl/pyramid_shape_function_eval.sv
sim/tb_top.sv
